// ===== sv/fifo_page_replacement_core_assert.svh =====
// ----------------------------------------------------------------------------
// FIFO page replacement core - assertion macros
// Shared property macros for the concurrent checks at the end of the top
// level. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FIFO_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define FPRC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define FPRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/fprc_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement package
// Sizes, field layout, controller state and the command/result types shared
// by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fprc_pkg;

	// Frame store size and page tag width
	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;

	// Fixed port field widths
	localparam int PAGE_W = 16;
	localparam int CFG_W  = 4;
	localparam int CNT_W  = 32;

	// Derived widths
	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FILL_W = $clog2(FRAMES + 1);
	localparam int LIM_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

	// Reset value of the frame limit register
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);

	// Output beat layout
	localparam int OUT_BITS = 2 + PAGE_W + 2 * CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	// Output register handshake state
	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic step;    // process the accepted reference and load the result
	} cmd_t;

	// Result of one reference
	typedef struct packed {
		cnt_t              refs;
		cnt_t              faults;
		logic [PAGE_W-1:0] ev_page;
		logic              ev_valid;
		logic              hit;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/fprc_ctrl.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement controller
// Tracks whether the output register holds an undelivered beat and issues
// the step command for every accepted reference.
// ----------------------------------------------------------------------------
`default_nettype none

module fprc_ctrl
	import fprc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and outputs: a new beat may enter while the old one leaves
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.step  = 1'b0;
		case (state_q)
			ST_EMPTY: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.step = 1'b1;
					state_d  = ST_FULL;
				end
			end
			ST_FULL: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.step = 1'b1;
					end else begin
						state_d = ST_EMPTY;
					end
				end
			end
			default: begin
				state_d = ST_EMPTY;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/fprc_dp.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement datapath
// Frame tag store with parallel compare, fill count, round-robin victim
// pointer, saturating counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fprc_dp
	import fprc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	input  wire cmd_t              cmd,
	input  wire logic [PAGE_W-1:0] page_number,
	output result_t                result
);

	// Architectural state
	page_t              pages_q [FRAMES];
	logic [FRAMES-1:0]  valid_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [FILL_W-1:0]  filled_q;
	cnt_t               faults_q;
	cnt_t               refs_q;
	logic [CFG_W-1:0]   limit_cfg_q;
	result_t            result_q;

	// Per-reference logic
	page_t              page;
	logic [FRAMES-1:0]  match;
	logic               hit;
	logic [LIM_W-1:0]   lim;
	logic [LIM_W-1:0]   cfg_ext;
	logic               fill_ok;
	logic [IDX_W-1:0]   victim;
	logic [IDX_W-1:0]   ptr_next;
	logic [IDX_W-1:0]   wr_idx;
	logic               ev_valid;
	page_t              ev_page;
	cnt_t               faults_next;
	cnt_t               refs_next;

	// Tag compare over all frames
	always_comb begin
		page = PAGE_BITS'(page_number);
		for (int i = 0; i < FRAMES; i++) begin
			match[i] = valid_q[i] && (pages_q[i] == page);
		end
		hit = |match;
	end

	// Effective limit: zero counts as one, clamp to store size
	always_comb begin
		cfg_ext = LIM_W'(limit_cfg_q);
		if (cfg_ext == '0) begin
			lim = LIM_W'(1);
		end else if (cfg_ext > LIM_W'(FRAMES)) begin
			lim = LIM_W'(FRAMES);
		end else begin
			lim = cfg_ext;
		end
	end

	// Placement: next free frame, else oldest frame below the limit
	always_comb begin
		fill_ok = (LIM_W'(filled_q) < lim) && (filled_q < FILL_W'(FRAMES));
		victim  = (LIM_W'(ptr_q) < lim) ? ptr_q : '0;
		if ((LIM_W'(victim) + LIM_W'(1)) >= lim) begin
			ptr_next = '0;
		end else begin
			ptr_next = victim + IDX_W'(1);
		end
		wr_idx   = fill_ok ? filled_q[IDX_W-1:0] : victim;
		ev_valid = !hit && !fill_ok && valid_q[victim];
		ev_page  = ev_valid ? pages_q[victim] : '0;
	end

	// Saturating counters
	always_comb begin
		refs_next   = (&refs_q) ? refs_q : refs_q + CNT_W'(1);
		faults_next = faults_q;
		if (!hit && !(&faults_q)) begin
			faults_next = faults_q + CNT_W'(1);
		end
	end

	// Frame tags, no reset: read only where the valid bit is set
	always_ff @(posedge clk) begin
		if (cmd.step && !hit) begin
			pages_q[wr_idx] <= page;
		end
	end

	// Control state and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			ptr_q       <= '0;
			filled_q    <= '0;
			faults_q    <= '0;
			refs_q      <= '0;
			limit_cfg_q <= CFG_RESET;
		end else begin
			if (cfg_wen) begin
				limit_cfg_q <= cfg_wdata;
			end
			if (cmd.step) begin
				refs_q   <= refs_next;
				faults_q <= faults_next;
				if (!hit) begin
					valid_q[wr_idx] <= 1'b1;
					if (fill_ok) begin
						filled_q <= filled_q + FILL_W'(1);
					end else begin
						ptr_q <= ptr_next;
					end
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			result_q.hit      <= hit;
			result_q.ev_valid <= ev_valid;
			result_q.ev_page  <= PAGE_W'(ev_page);
			result_q.faults   <= faults_next;
			result_q.refs     <= refs_next;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

// ===== sv/fifo_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// FIFO page replacement core
// Takes one page reference per beat and returns one result beat per
// reference. A reference is accepted every clock while results are taken;
// it is compared against all resident frames in the cycle it is accepted,
// and its result shows on the output in the next cycle. The throughput of one
// reference per clock rests on the combinational tag compare and pointer
// update in the datapath. A stalled output holds one beat, and input is then
// taken only in a cycle in which that beat leaves. frames_in_use is written
// through cfg_wen/cfg_wdata and must only change while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fifo_page_replacement_core_assert.svh"

module fifo_page_replacement_core
	import fprc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration: frames_in_use
	input  wire logic              cfg_wen,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	// Reference stream
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [PAGE_W-1:0] s_tdata,   // [15:0] page_number
	// Result stream
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [OUT_W-1:0]       m_tdata    // [0] hit, [1] evicted_valid,
	                                          // [17:2] evicted_page,
	                                          // [49:18] fault_count,
	                                          // [81:50] reference_count, zero pad
);

	cmd_t    cmd;
	result_t result;

	fprc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	fprc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.page_number (s_tdata),
		.result      (result)
	);

	// Output beat packing
	assign m_tdata = OUT_W'(result);

	// Checks
	`FPRC_ASSERT_NOW(a_no_overrun, m_tvalid && !m_tready, !s_tready, "accept over held beat")
	`FPRC_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid, "accepted beat lost")
	`FPRC_ASSERT_NOW(a_evict_on_fault, m_tvalid && m_tdata[1], !m_tdata[0], "eviction on hit")
	`FPRC_ASSERT_NOW(a_faults_le_refs, m_tvalid, m_tdata[49:18] <= m_tdata[81:50],
		"fault count above reference count")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FIFO page replacement core testbench
// Sends page references through the input stream and checks every result
// beat against a predictor that holds its own frame table, round-robin
// pointer and saturating counters. The directed references come first. They
// fill the frames, hit, evict, lower the limit below the filled count, move
// the pointer past the limit, and use limits of zero and above the frame
// count. Random phases follow, each with a new frame limit and a small page
// pool, so that hits and evictions are both common. The sender idles in
// bursts and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------

module tb_top;
	import fprc_pkg::*;

	localparam int REFS_PER_PHASE = 100;
	localparam int RANDOM_PHASES  = 12;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_wen   = 1'b0;
	logic [CFG_W-1:0]  cfg_wdata = CFG_RESET;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [PAGE_W-1:0] s_tdata   = '0;   // [15:0] page_number
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_W-1:0]  m_tdata;          // [0] hit, [1] evicted_valid,
	                                     // [17:2] evicted_page,
	                                     // [49:18] fault_count,
	                                     // [81:50] reference_count

	// Pending references and expected result beats
	page_t   page_q[$];
	result_t expected_results[$];

	// Predictor state
	page_t            held_page[FRAMES];
	logic             resident[FRAMES];
	int               oldest;
	int               fill_count;
	cnt_t             faults_seen;
	cnt_t             refs_seen;
	logic [CFG_W-1:0] frame_limit = CFG_RESET;

	// Bookkeeping
	int      errors         = 0;
	int      results_seen   = 0;
	int      hits_seen      = 0;
	int      evictions_seen = 0;
	int      limit_writes   = 0;
	int      burst_left     = 0;
	int      gap_left       = 0;
	int      ready_cycle    = 0;
	logic [7:0] stall_pattern = 8'hFF;
	result_t got_beat;
	result_t want_beat;

	fifo_page_replacement_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predict one reference and advance the frame table
	function automatic result_t predict_reference(input page_t page);
		result_t r;
		int      lim;
		int      victim;
		logic    found;
		r = '0;
		found = 1'b0;
		if (frame_limit == 0)
			lim = 1;
		else if (frame_limit > FRAMES)
			lim = FRAMES;
		else
			lim = frame_limit;
		if (refs_seen != '1)
			refs_seen++;
		for (int i = 0; i < FRAMES; i++)
			if (resident[i] && held_page[i] == page)
				found = 1'b1;
		if (!found) begin
			if (faults_seen != '1)
				faults_seen++;
			if (fill_count < lim) begin
				held_page[fill_count] = page;
				resident[fill_count] = 1'b1;
				fill_count++;
			end else begin
				// a pointer past the limit falls back to frame 0
				victim = (oldest < lim) ? oldest : 0;
				if (resident[victim]) begin
					r.ev_valid = 1'b1;
					r.ev_page = held_page[victim];
				end
				held_page[victim] = page;
				resident[victim] = 1'b1;
				oldest = (victim + 1 >= lim) ? 0 : victim + 1;
			end
		end
		r.hit = found;
		r.faults = faults_seen;
		r.refs = refs_seen;
		return r;
	endfunction

	// Reference driver: bursts of random length, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left > 0 || page_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= page_q.pop_front();
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// Result receiver: ready steps through an eight-bit stall pattern that is periodically redrawn
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_cycle = 0;
		end else begin
			if (ready_cycle % 64 == 0)
				stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF :
					(8'($urandom) | (8'h01 << $urandom_range(0, 7)));
			m_tready <= stall_pattern[ready_cycle % 8];
			ready_cycle++;
		end
	end

	// Monitor: predict on accepted references, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_reference(s_tdata));
			if (m_tvalid && m_tready) begin
				got_beat = result_t'(m_tdata[OUT_BITS-1:0]);
				results_seen++;
				if (got_beat.hit)
					hits_seen++;
				if (got_beat.ev_valid)
					evictions_seen++;
				if (expected_results.size() == 0) begin
					$error("result beat with no reference pending");
					errors++;
				end else begin
					want_beat = expected_results.pop_front();
					if (got_beat.hit !== want_beat.hit) begin
						$error("hit: expected %0d, actual %0d", want_beat.hit, got_beat.hit);
						errors++;
					end
					if (got_beat.ev_valid !== want_beat.ev_valid) begin
						$error("evicted_valid: expected %0d, actual %0d",
							want_beat.ev_valid, got_beat.ev_valid);
						errors++;
					end
					if (got_beat.ev_page !== want_beat.ev_page) begin
						$error("evicted_page: expected %h, actual %h",
							want_beat.ev_page, got_beat.ev_page);
						errors++;
					end
					if (got_beat.faults !== want_beat.faults) begin
						$error("fault_count: expected %0d, actual %0d",
							want_beat.faults, got_beat.faults);
						errors++;
					end
					if (got_beat.refs !== want_beat.refs) begin
						$error("reference_count: expected %0d, actual %0d",
							want_beat.refs, got_beat.refs);
						errors++;
					end
				end
			end
		end
	end

	// Write frames_in_use; only called with nothing in flight
	task automatic write_frame_limit(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		frame_limit = value;
		limit_writes++;
	endtask

	// Wait until every reference is sent and every result is back
	task automatic drain();
		do
			@(negedge clk);
		while (page_q.size() != 0 || s_tvalid || expected_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// Stimulus sequence
	initial begin
		page_t            pool[$];
		int               pool_n;
		logic [CFG_W-1:0] limit_value;
		logic [CFG_W-1:0] extremes[5];

		extremes = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9};
		for (int i = 0; i < FRAMES; i++) begin
			held_page[i] = '0;
			resident[i] = 1'b0;
		end
		oldest = 0;
		fill_count = 0;
		faults_seen = '0;
		refs_seen = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limit of 3: fill, hit, then evict in FIFO order
		page_q = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8001, 16'hFFFF,
			16'h7FFE, 16'h5555, 16'hAAAA, 16'h7FFE};
		drain();
		// All frames: fill the rest, then wrap to frame 0
		write_frame_limit(4'd8);
		page_q = '{16'h0101, 16'h0202, 16'h0303, 16'h0404, 16'h0505, 16'h0606};
		drain();
		// Limit below the filled count: upper frames still hit
		write_frame_limit(4'd2);
		page_q = '{16'h0505, 16'h1111, 16'h2222};
		drain();
		// Zero acts as one frame
		write_frame_limit(4'd0);
		page_q = '{16'h3333, 16'h0404};
		drain();
		// Above the frame count saturates; move the pointer up
		write_frame_limit(4'd15);
		page_q = '{16'h4444, 16'h4545, 16'h4646};
		drain();
		// Pointer now beyond the limit: replacement takes frame 0
		write_frame_limit(4'd2);
		page_q = '{16'h4747};
		drain();

		// Random phases, each with its own limit and page pool
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			limit_value = (phase < 5) ? extremes[phase] : 4'($urandom_range(0, 15));
			write_frame_limit(limit_value);
			pool_n = $urandom_range(2, 12);
			pool.delete();
			for (int i = 0; i < pool_n; i++)
				pool.push_back(page_t'($urandom));
			for (int n = 0; n < REFS_PER_PHASE; n++) begin
				if ($urandom_range(0, 4) == 0)
					page_q.push_back(page_t'($urandom));
				else
					page_q.push_back(pool[$urandom_range(0, pool_n - 1)]);
			end
			drain();
		end

		repeat (5) @(posedge clk);
		$display("checked %0d result beats: %0d hits, %0d evictions",
			results_seen, hits_seen, evictions_seen);
		$display("frames_in_use written %0d times, limits 0 to 15", limit_writes);
		if (errors == 0)
			$display("fifo_page_replacement_core regression: pass");
		else
			$display("fifo_page_replacement_core regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("fifo_page_replacement_core regression: fail");
		$finish;
	end

endmodule
